@@ rtl/core/credit_gated_command_admission_assert.svh @@
// Assertion macros shared by the admission logic.
`ifndef CREDIT_GATED_COMMAND_ADMISSION_ASSERT_SVH
`define CREDIT_GATED_COMMAND_ADMISSION_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CGCA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define CGCA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define CGCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cgca_pkg.sv @@
package cgca_pkg;

   localparam int unsigned QUEUE_DEPTH = 64;
   localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W       = FILL_W + 1;

   localparam int unsigned COST_W  = 16;
   localparam int unsigned ENTRY_W = COST_W + 1;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned PPS_W   = 16;
   localparam int unsigned TPS_W   = 10;
   localparam int unsigned CAP_W   = 16;

   localparam int unsigned DIVIDEND_W = PPS_W;
   localparam int unsigned DIVISOR_W  = TPS_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_POINTS_PER_SECOND = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_TICKS_PER_SECOND  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_POINT_CAPACITY    = 2'd2;

   localparam logic [PPS_W-1:0] PPS_RESET = 16'd10;
   localparam logic [TPS_W-1:0] TPS_RESET = 10'd20;
   localparam logic [CAP_W-1:0] CAP_RESET = 16'd1000;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [COST_W-1:0] command_cost;
      logic              cost_counts;
   } cgca_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] admitted_count;
      logic [CAP_W-1:0] points_left;
      logic             enqueue_refused;
   } cgca_rsp_type;

endpackage

@@ rtl/core/cgca_ram.sv @@
module cgca_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/cgca_div.sv @@
module cgca_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cgca_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [cgca_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                done,
   output logic [cgca_pkg::DIVIDEND_W-1:0]     quotient,
   output logic [cgca_pkg::DIVISOR_W-1:0]      remainder
);

   localparam int unsigned NW = cgca_pkg::DIVIDEND_W;
   localparam int unsigned DW = cgca_pkg::DIVISOR_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cgca_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NW-1:0]                     quo_ff, quo_in;
   logic [DW-1:0]                     rem_ff, rem_in;
   logic [DW:0]                       trial;
   logic [DW:0]                       diff;
   logic                              fits;

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      fits    = (trial >= {1'b0, divisor});
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = cgca_pkg::DIV_CNT_W'(NW);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == cgca_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/credit_gated_command_admission.sv @@
// Token bucket in front of an in-order command queue held in a single-port-read RAM.
// An enqueue beat goes from acceptance through ST_DONE to the output register. A tick beat
// passes ST_DIV_GAIN, ST_DIV_PHASE, ST_SCAN_START and, if fill is nonzero, ST_SCAN: one
// shared bit-serial divider runs twice (points per tick, then the phase wrap), and the
// admission scan then reads one queue entry per cycle from the RAM. The result waits
// in an output register, and the block accepts beats again while it is held; a finished
// item waits in ST_DONE until the register is free or being taken.
`include "credit_gated_command_admission_assert.svh"

module credit_gated_command_admission (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cgca_pkg::cgca_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cgca_pkg::cgca_rsp_type              rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cgca_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cgca_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cgca_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned IDX_W  = cgca_pkg::IDX_W;
   localparam int unsigned FILL_W = cgca_pkg::FILL_W;
   localparam int unsigned SUM_W  = cgca_pkg::SUM_W;
   localparam int unsigned CAP_W  = cgca_pkg::CAP_W;
   localparam int unsigned CNT_W  = cgca_pkg::CNT_W;
   localparam int unsigned TPS_W  = cgca_pkg::TPS_W;

   localparam int unsigned ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE       = 3'd0;
   localparam logic [ST_W-1:0] ST_DIV_GAIN   = 3'd1;
   localparam logic [ST_W-1:0] ST_DIV_PHASE  = 3'd2;
   localparam logic [ST_W-1:0] ST_SCAN_START = 3'd3;
   localparam logic [ST_W-1:0] ST_SCAN       = 3'd4;
   localparam logic [ST_W-1:0] ST_DONE       = 3'd5;

   function automatic logic [IDX_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] w;
      w = (s >= SUM_W'(cgca_pkg::QUEUE_DEPTH)) ? (s - SUM_W'(cgca_pkg::QUEUE_DEPTH)) : s;
      return w[IDX_W-1:0];
   endfunction

   // Configuration registers.
   logic [cgca_pkg::PPS_W-1:0]  pps_ff;
   logic [TPS_W-1:0]            tps_ff;
   logic [CAP_W-1:0]            cap_ff;
   logic                        csr_write;
   logic [cgca_pkg::REG_IDX_W-1:0] csr_idx;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[cgca_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pps_ff <= cgca_pkg::PPS_RESET;
         tps_ff <= cgca_pkg::TPS_RESET;
         cap_ff <= cgca_pkg::CAP_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            cgca_pkg::REG_POINTS_PER_SECOND: pps_ff <= csr_pwdata[cgca_pkg::PPS_W-1:0];
            cgca_pkg::REG_TICKS_PER_SECOND:  tps_ff <= csr_pwdata[TPS_W-1:0];
            cgca_pkg::REG_POINT_CAPACITY:    cap_ff <= csr_pwdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         cgca_pkg::REG_POINTS_PER_SECOND:
            csr_prdata = cgca_pkg::CSR_DATA_W'(pps_ff);
         cgca_pkg::REG_TICKS_PER_SECOND:
            csr_prdata = cgca_pkg::CSR_DATA_W'(tps_ff);
         cgca_pkg::REG_POINT_CAPACITY:
            csr_prdata = cgca_pkg::CSR_DATA_W'(cap_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // A zero tick rate behaves as one tick per second.
   logic [TPS_W-1:0] divisor;
   assign divisor = (tps_ff == '0) ? TPS_W'(1) : tps_ff;

   // Control and bucket state.
   logic [ST_W-1:0]   state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CAP_W-1:0]  bucket_ff, bucket_in;
   logic [TPS_W-1:0]  phase_ff, phase_in;
   logic [FILL_W-1:0] adm_before_ff, adm_before_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic              refused_ff, refused_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cgca_pkg::cgca_rsp_type rsp_data_ff, rsp_data_in;

   // Queue RAM ports.
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [cgca_pkg::ENTRY_W-1:0]  wr_data;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic [cgca_pkg::ENTRY_W-1:0]  rd_data;

   // Divider ports.
   logic                              div_start;
   logic [cgca_pkg::DIVIDEND_W-1:0]   div_dividend;
   logic                              div_done;
   logic [cgca_pkg::DIVIDEND_W-1:0]   div_quo;
   logic [TPS_W-1:0]                  div_rem;

   logic                      req_fire;
   logic [FILL_W-1:0]         drop;
   logic [FILL_W-1:0]         fill_dropped;
   logic [CAP_W+1:0]          acc_sum;
   logic [CAP_W-1:0]          entry_cost;
   logic [FILL_W-1:0]         cnt_next;
   logic [TPS_W:0]            phase_inc;
   logic [FILL_W+CNT_W-1:0]   cnt_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      drop         = (adm_before_ff < fill_ff) ? adm_before_ff : fill_ff;
      fill_dropped = fill_ff - drop;
      acc_sum      = {2'b00, bucket_ff} + (CAP_W+2)'(div_quo)
                     + (CAP_W+2)'(phase_ff < div_rem);
      entry_cost   = rd_data[cgca_pkg::COST_W] ? rd_data[CAP_W-1:0] : '0;
      cnt_next     = cnt_ff + 1'b1;
      phase_inc    = {1'b0, phase_ff} + 1'b1;
      cnt_wide     = {CNT_W'(0), cnt_ff};

      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      bucket_in     = bucket_ff;
      phase_in      = phase_ff;
      adm_before_in = adm_before_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      refused_in    = refused_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      wr_en        = 1'b0;
      wr_addr      = wrap_sum(SUM_W'(head_ff) + SUM_W'(fill_ff));
      wr_data      = {req_data.cost_counts, req_data.command_cost};
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      div_start    = 1'b0;
      div_dividend = pps_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in     = '0;
               refused_in = 1'b0;
               if (req_data.req_type == cgca_pkg::REQ_ENQUEUE) begin
                  if (fill_ff == FILL_W'(cgca_pkg::QUEUE_DEPTH)) begin
                     refused_in = 1'b1;
                  end else begin
                     wr_en   = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
                  state_in = ST_DONE;
               end else begin
                  // Retire what the previous tick admitted, then size this tick's gain.
                  head_in   = wrap_sum(SUM_W'(head_ff) + SUM_W'(drop));
                  fill_in   = fill_dropped;
                  div_start = 1'b1;
                  state_in  = ST_DIV_GAIN;
               end
            end
         end
         ST_DIV_GAIN: begin
            if (div_done) begin
               bucket_in    = (acc_sum > {2'b00, cap_ff}) ? cap_ff : acc_sum[CAP_W-1:0];
               div_start    = 1'b1;
               div_dividend = cgca_pkg::DIVIDEND_W'(phase_inc);
               state_in     = ST_DIV_PHASE;
            end
         end
         ST_DIV_PHASE: begin
            if (div_done) begin
               phase_in = div_rem;
               state_in = ST_SCAN_START;
            end
         end
         ST_SCAN_START: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
            ptr_in  = wrap_sum(SUM_W'(head_ff) + SUM_W'(1));
            cnt_in  = '0;
            if (fill_ff == '0) begin
               adm_before_in = '0;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The entry for cnt_ff arrives now; the next one is fetched ahead.
            rd_en  = 1'b1;
            ptr_in = wrap_sum(SUM_W'(ptr_ff) + SUM_W'(1));
            if (entry_cost > bucket_ff) begin
               adm_before_in = cnt_ff;
               state_in      = ST_DONE;
            end else begin
               bucket_in = bucket_ff - entry_cost;
               cnt_in    = cnt_next;
               if (cnt_next == fill_ff) begin
                  adm_before_in = cnt_next;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.admitted_count  = cnt_wide[CNT_W-1:0];
               rsp_data_in.points_left     = bucket_ff;
               rsp_data_in.enqueue_refused = refused_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         bucket_ff     <= cgca_pkg::CAP_RESET;
         phase_ff      <= '0;
         adm_before_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         bucket_ff     <= bucket_in;
         phase_ff      <= phase_in;
         adm_before_ff <= adm_before_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      ptr_ff      <= ptr_in;
      refused_ff  <= refused_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cgca_ram #(
      .WIDTH (cgca_pkg::ENTRY_W),
      .DEPTH (cgca_pkg::QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cgca_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   `CGCA_ASSERT_HOLDS(a_fill_bound, clock, reset, fill_ff <= FILL_W'(cgca_pkg::QUEUE_DEPTH), "queue fill beyond depth")
   `CGCA_ASSERT_IMPLIES(a_admitted_within_fill, clock, reset, state_ff == ST_IDLE, adm_before_ff <= fill_ff, "admitted count exceeds queue fill while idle")
   `CGCA_ASSERT_IMPLIES(a_scan_within_fill, clock, reset, state_ff == ST_SCAN, cnt_ff < fill_ff, "scan ran past the queue fill")
   `CGCA_ASSERT_IMPLIES(a_phase_wrapped, clock, reset, state_ff == ST_SCAN_START, phase_ff < divisor, "tick phase not wrapped below tick rate")
   `CGCA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "accepted a beat while an item is still in work")

endmodule
